@@ hdl/pwn_pkg.sv @@
// ----------------------------------------------------------------------------
// pwn_pkg
// Shared types and constants for the polygon winding number block.
// ----------------------------------------------------------------------------
package pwn_pkg;

    localparam int LAT_W  = 28;
    localparam int LON_W  = 29;
    localparam int VTX_W  = LAT_W + LON_W;
    localparam int WIND_W = 9;
    localparam int STAT_W = 3;
    localparam int CNT_W  = 9;
    localparam int FUNC_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_ANSWERED   = 3'd0;
    localparam logic [STAT_W-1:0] STAT_STORED     = 3'd1;
    localparam logic [STAT_W-1:0] STAT_DROPPED    = 3'd2;
    localparam logic [STAT_W-1:0] STAT_CLEARED    = 3'd3;
    localparam logic [STAT_W-1:0] STAT_DEGENERATE = 3'd4;

    typedef struct packed {
        logic              load;
        logic              wr_en;
        logic              clr;
        logic              rd_en;
        logic              out_load;
        logic [STAT_W-1:0] code;
    } pwn_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              pipe_busy;
        logic              out_free;
    } pwn_sts_t;

endpackage

@@ hdl/pwn_ctrl.sv @@
// ----------------------------------------------------------------------------
// pwn_ctrl
// Sequencer: decodes each item and walks the vertex table for queries.
// ----------------------------------------------------------------------------
module pwn_ctrl #(
    parameter int MAX_VERTICES = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  pwn_pkg::pwn_sts_t                  sts,
    input  logic [$clog2(MAX_VERTICES+1)-1:0]  count,
    output pwn_pkg::pwn_cmd_t                  cmd,
    output logic [$clog2(MAX_VERTICES)-1:0]    rd_addr
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_DRAIN,
        S_FINISH
    } state_t;

    state_t                     state_reg, state_next;
    logic [AW-1:0]              addr_reg, addr_next;
    logic [pwn_pkg::STAT_W-1:0] code_reg, code_next;

    always_comb begin
        state_next = state_reg;
        addr_next  = addr_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.code   = code_reg;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (sts.func)
                    pwn_pkg::FUNC_APPEND: begin
                        if (count < CW'(MAX_VERTICES)) begin
                            cmd.wr_en = 1'b1;
                            code_next = pwn_pkg::STAT_STORED;
                        end else begin
                            code_next = pwn_pkg::STAT_DROPPED;
                        end
                        state_next = S_FINISH;
                    end
                    pwn_pkg::FUNC_QUERY: begin
                        if (count < CW'(2)) begin
                            code_next  = pwn_pkg::STAT_DEGENERATE;
                            state_next = S_FINISH;
                        end else begin
                            addr_next  = '0;
                            state_next = S_WALK;
                        end
                    end
                    default: begin
                        cmd.clr    = 1'b1;
                        code_next  = pwn_pkg::STAT_CLEARED;
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_WALK: begin
                cmd.rd_en = 1'b1;
                addr_next = addr_reg + AW'(1);
                if (CW'(addr_reg) + CW'(1) == count) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!sts.pipe_busy) begin
                    code_next  = pwn_pkg::STAT_ANSWERED;
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rd_addr = addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            addr_reg  <= '0;
            code_reg  <= pwn_pkg::STAT_ANSWERED;
        end else begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            code_reg  <= code_next;
        end
    end

endmodule

@@ hdl/pwn_datapath.sv @@
// ----------------------------------------------------------------------------
// pwn_datapath
// Vertex memory, edge crossing pipeline, winding accumulator, result register.
// ----------------------------------------------------------------------------
module pwn_datapath #(
    parameter int MAX_VERTICES = 256
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [63:0]                           s_tdata,
    input  logic [1:0]                            s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [23:0]                           m_tdata,
    output logic [2:0]                            m_tuser,
    input  pwn_pkg::pwn_cmd_t                     cmd,
    input  logic [$clog2(MAX_VERTICES)-1:0]       rd_addr,
    output pwn_pkg::pwn_sts_t                     sts,
    output logic [$clog2(MAX_VERTICES+1)-1:0]     count
);

    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int CW    = $clog2(MAX_VERTICES + 1);
    localparam int WW    = ($clog2(MAX_VERTICES) + 2 > 10) ? $clog2(MAX_VERTICES) + 2 : 10;
    localparam int LAT_W = pwn_pkg::LAT_W;
    localparam int LON_W = pwn_pkg::LON_W;
    localparam int VTX_W = pwn_pkg::VTX_W;
    localparam int PR_W  = LAT_W + LON_W + 2;

    // latched item
    logic [pwn_pkg::FUNC_W-1:0] func_reg;
    logic signed [LAT_W-1:0]    plat_reg;
    logic signed [LON_W-1:0]    plon_reg;

    logic [CW-1:0]              count_reg;

    // vertex memory, lat in the upper bits
    logic [VTX_W-1:0]           mem [MAX_VERTICES];
    logic [VTX_W-1:0]           rdata_reg;
    logic [VTX_W-1:0]           prev_reg;
    logic                       rd_valid_reg;
    logic                       rd_first_reg;

    // edge stages
    logic                       s1_valid_reg;
    logic                       s1_up_reg, s1_dn_reg;
    logic signed [LAT_W:0]      dlat_reg, dlatp_reg;
    logic signed [LON_W:0]      dlon_reg, dlonp_reg;
    logic                       s2_valid_reg;
    logic                       s2_up_reg, s2_dn_reg;
    logic signed [PR_W-1:0]     p1_reg, p2_reg;

    logic signed [WW-1:0]       wn_reg, wn_next;

    logic                       m_tvalid_reg;
    logic [23:0]                m_tdata_reg;
    logic [2:0]                 m_tuser_reg;

    logic signed [LAT_W-1:0]    lat0, lat1;
    logic signed [LON_W-1:0]    lon0, lon1;
    logic signed [LAT_W:0]      dlat_next, dlatp_next;
    logic signed [LON_W:0]      dlon_next, dlonp_next;
    logic signed [PR_W:0]       side;
    logic signed [pwn_pkg::WIND_W-1:0] wn_sat;
    logic                       out_free;
    logic                       edge_valid;

    assign out_free   = !m_tvalid_reg || m_tready;
    assign edge_valid = rd_valid_reg && !rd_first_reg;

    assign lat0 = prev_reg[VTX_W-1:LON_W];
    assign lon0 = prev_reg[LON_W-1:0];
    assign lat1 = rdata_reg[VTX_W-1:LON_W];
    assign lon1 = rdata_reg[LON_W-1:0];

    always_comb begin
        dlat_next  = (LAT_W+1)'(lat1) - (LAT_W+1)'(lat0);
        dlatp_next = (LAT_W+1)'(plat_reg) - (LAT_W+1)'(lat0);
        dlon_next  = (LON_W+1)'(lon1) - (LON_W+1)'(lon0);
        dlonp_next = (LON_W+1)'(plon_reg) - (LON_W+1)'(lon0);
    end

    always_comb begin
        side    = (PR_W+1)'(p1_reg) - (PR_W+1)'(p2_reg);
        wn_next = wn_reg;
        if (s2_valid_reg && s2_up_reg && side > 0) begin
            wn_next = wn_reg + WW'(1);
        end else if (s2_valid_reg && s2_dn_reg && side < 0) begin
            wn_next = wn_reg - WW'(1);
        end
    end

    always_comb begin
        if (wn_reg > WW'(255)) begin
            wn_sat = 9'sd255;
        end else if (wn_reg < -WW'(255)) begin
            wn_sat = -9'sd255;
        end else begin
            wn_sat = pwn_pkg::WIND_W'(wn_reg);
        end
    end

    // memory
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[count_reg[AW-1:0]] <= {plat_reg, plon_reg};
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= s_tuser;
            plat_reg <= s_tdata[LAT_W-1:0];
            plon_reg <= s_tdata[VTX_W-1:LAT_W];
        end
        if (rd_valid_reg) begin
            prev_reg <= rdata_reg;
        end
        if (cmd.rd_en) begin
            rd_first_reg <= (rd_addr == '0);
        end
        dlat_reg  <= dlat_next;
        dlatp_reg <= dlatp_next;
        dlon_reg  <= dlon_next;
        dlonp_reg <= dlonp_next;
        s1_up_reg <= (lon0 <= plon_reg) && (lon1 > plon_reg);
        s1_dn_reg <= (lon0 > plon_reg) && (lon1 <= plon_reg);
        p1_reg    <= dlat_reg * dlonp_reg;
        p2_reg    <= dlatp_reg * dlon_reg;
        s2_up_reg <= s1_up_reg;
        s2_dn_reg <= s1_dn_reg;
        if (cmd.out_load) begin
            m_tdata_reg <= {6'd0, pwn_pkg::CNT_W'(count_reg), wn_sat};
            m_tuser_reg <= cmd.code;
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            wn_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.clr) begin
                count_reg <= '0;
            end else if (cmd.wr_en) begin
                count_reg <= count_reg + CW'(1);
            end
            rd_valid_reg <= cmd.rd_en;
            s1_valid_reg <= edge_valid;
            s2_valid_reg <= s1_valid_reg;
            if (cmd.load) begin
                wn_reg <= '0;
            end else begin
                wn_reg <= wn_next;
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign sts.func      = func_reg;
    assign sts.pipe_busy = rd_valid_reg || s1_valid_reg || s2_valid_reg;
    assign sts.out_free  = out_free;
    assign count         = count_reg;
    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;
    assign m_tuser       = m_tuser_reg;

endmodule

@@ hdl/polygon_winding_number_top.sv @@
// A vertex append or a clear passes the decode and finish states from accepted beat to
// result beat. In a query, the walk reads one vertex from the table memory per cycle,
// one edge per cycle, followed by a short drain of the cross-product pipeline.
// One item is in progress at a time; the next beat is accepted while a finished result
// still waits on the output register. Status codes: 0 answered, 1 stored, 2 dropped
// (table full), 3 cleared, 4 degenerate (fewer than two vertices, winding 0). Only the
// open chain of edges is walked, no closing edge. No clearing pass after reset.
// ----------------------------------------------------------------------------
// polygon_winding_number_top
// Winding number of a query point against a stored polygon vertex table.
// ----------------------------------------------------------------------------
module polygon_winding_number_top #(
    parameter int MAX_VERTICES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // coord_lat[27:0], coord_lon[56:28], zero pad
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // winding[8:0], vertex_count[17:9], zero pad
    output logic [2:0]  m_tuser    // status[2:0]
);

    pwn_pkg::pwn_cmd_t                    cmd;
    pwn_pkg::pwn_sts_t                    sts;
    logic [$clog2(MAX_VERTICES)-1:0]      rd_addr;
    logic [$clog2(MAX_VERTICES+1)-1:0]    count;

    pwn_ctrl #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .sts     (sts),
        .count   (count),
        .cmd     (cmd),
        .rd_addr (rd_addr)
    );

    pwn_datapath #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .cmd     (cmd),
        .rd_addr (rd_addr),
        .sts     (sts),
        .count   (count)
    );

endmodule

@@ hdl/pwn_checker.sv @@
// ----------------------------------------------------------------------------
// pwn_checker
// Port-level checks for the polygon winding number block.
// ----------------------------------------------------------------------------
module pwn_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [63:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat dropped or changed while stalled");

    // no result right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // status code in range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= pwn_pkg::STAT_DEGENERATE))
        else $error("status code out of range");

    // winding only nonzero on answered queries
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != pwn_pkg::STAT_ANSWERED) |-> (m_tdata[8:0] == 9'd0))
        else $error("nonzero winding on non-query result");

    // an input beat is never accepted in the cycle right after the previous one
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on back-to-back cycles");

endmodule

bind polygon_winding_number_top pwn_checker u_pwn_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);
